>>> src/cop0_pkg.sv
`timescale 1ns / 1ps
package cop0_pkg;

  typedef enum logic [2:0] {
    CMD_READ_REG   = 3'd0,
    CMD_WRITE_REG  = 3'd1,
    CMD_TLB_READ   = 3'd2,
    CMD_TLB_WRITE  = 3'd3,
    CMD_TLB_WRITER = 3'd4,
    CMD_TLB_PROBE  = 3'd5,
    CMD_NOP6       = 3'd6,
    CMD_NOP7       = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  reg_index;
    logic [63:0] write_value;
    logic [4:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        random_reset;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_RD_WB,
    ST_PROBE,
    ST_PROBE_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic        hit;
    logic        busy;
  } probe_ctl_t;

  localparam logic [63:0] MASK_INDEX    = 64'h0000_0000_8000_003f;
  localparam logic [63:0] MASK_LO       = 64'h0000_0000_3fff_ffff;
  localparam logic [63:0] MASK_PAGEMASK = 64'h0000_0000_01ff_e000;
  localparam logic [63:0] MASK_ENTRYHI  = 64'hc000_00ff_ffff_e0ff;
  localparam logic [63:0] MASK_STATUS   = 64'h0000_0000_ff57_ffff;
  localparam logic [63:0] MASK_CONFIG   = 64'h0000_0000_0f00_800f;
  localparam logic [63:0] MASK_WATCHLO  = 64'h0000_0000_ffff_fffb;
  localparam logic [24:0] MASK_PM_SRC   = 25'h155_4000;
  localparam logic [25:0] MASK_PFN      = 26'h3ff_fffe;
  localparam logic [63:0] MASK_VPN      = 64'hc000_00ff_ffff_e000;
  localparam logic [63:0] PROBE_MISS    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MASK_XCTX     = 64'h0000_0001_ffff_ffff;

endpackage

>>> src/system_coprocessor_regs_and_tlb.sv
`timescale 1ns / 1ps
// System-control coprocessor with 32 masked 64-bit registers and a TLB of TLB_ENTRIES
// entries in a synchronous memory. After reset the block sweeps the TLB clearing every
// entry before the first transfer is accepted. Register reads and writes and TLB writes
// are done in ST_RD; a TLB read adds ST_RD_WB for the memory read data; a probe reads
// one entry per cycle through the single memory read port and compares it, stopping at
// the first hit or after the last entry. One item is in flight at a time; the result
// sits in an output register until taken.
module system_coprocessor_regs_and_tlb #(
  parameter int unsigned TLB_ENTRIES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cop0_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cop0_pkg::out_item_t  out_data_o
);
  import cop0_pkg::*;

  localparam int unsigned IdxW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TLB_ENTRIES + 1);
  localparam logic [CntW-1:0] Last = CntW'(TLB_ENTRIES - 1);

  state_e state_q, state_d;
  logic [63:0] regs_q [32];
  logic [63:0] latch_q;
  in_item_t item_q;
  out_item_t res_q, res_d;
  logic out_valid_q;
  logic clr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cmp_idx_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [24:0] wmask, rmask;
  logic [63:0] whigh, rhigh;
  logic [25:0] wlo0, wlo1, rlo0, rlo1;
  logic wg, rg;

  cop0_tlb_mem #(.TlbEntries(TLB_ENTRIES), .IdxW(IdxW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wmask_i(wmask), .whigh_i(whigh),
    .wlo0_i(wlo0), .wlo1_i(wlo1), .wg_i(wg), .raddr_i(raddr),
    .rmask_o(rmask), .rhigh_o(rhigh), .rlo0_o(rlo0), .rlo1_o(rlo1), .rg_o(rg)
  );

  // entry write path
  logic [24:0] pm_src, pm_new;
  logic g_new;
  logic [5:0] w_idx;
  logic w_ok;
  always_comb begin
    pm_src = regs_q[5][24:0] & MASK_PM_SRC;
    pm_new = pm_src | (pm_src >> 1);
    g_new = regs_q[2][0] & regs_q[3][0];
    w_idx = (item_q.command == CMD_TLB_WRITER) ? {1'b0, item_q.random_value}
                                               : regs_q[0][5:0];
    w_ok = {26'd0, w_idx} < TLB_ENTRIES;
  end

  // probe compare
  logic [63:0] vmask;
  logic match;
  always_comb begin
    vmask = MASK_VPN & ~{39'd0, rmask};
    match = ((regs_q[10] & vmask) == (rhigh & vmask))
            && (rg || (rhigh[7:0] == regs_q[10][7:0]));
  end

  logic [5:0] r_idx;
  assign r_idx = regs_q[0][5:0];

  assign in_stall_o = clr_q || (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = res_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    we = 1'b0;
    waddr = IdxW'(cnt_q);
    wmask = '0;
    whigh = '0;
    wlo0 = '0;
    wlo1 = '0;
    wg = 1'b0;
    raddr = IdxW'(r_idx);
    if (clr_q) begin
      we = 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            state_d = ST_RD;
          end
        end
        ST_RD: begin
          case (item_q.command)
            CMD_TLB_READ: begin
              state_d = ({26'd0, r_idx} < TLB_ENTRIES) ? ST_RD_WB : ST_DONE;
            end
            CMD_TLB_WRITE, CMD_TLB_WRITER: begin
              we = w_ok;
              waddr = IdxW'(w_idx);
              wmask = pm_new;
              whigh = regs_q[10] & ~{39'd0, pm_new};
              wlo0 = (regs_q[2][25:0] & MASK_PFN) | {25'd0, g_new};
              wlo1 = (regs_q[3][25:0] & MASK_PFN) | {25'd0, g_new};
              wg = g_new;
              state_d = ST_DONE;
            end
            CMD_TLB_PROBE: begin
              cnt_d = '0;
              raddr = '0;
              state_d = ST_PROBE;
            end
            default: state_d = ST_DONE;
          endcase
        end
        ST_RD_WB: state_d = ST_DONE;
        ST_PROBE: begin
          raddr = IdxW'(cnt_q);
          cnt_d = cnt_q + 1'b1;
          state_d = ST_PROBE_CMP;
        end
        ST_PROBE_CMP: begin
          raddr = IdxW'(cnt_q);
          if (match) begin
            state_d = ST_DONE;
          end else if (cmp_idx_q == Last) begin
            state_d = ST_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        ST_DONE: state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res_d = '0;
    case (item_q.command)
      CMD_READ_REG: begin
        case (item_q.reg_index)
          5'd1: res_d.read_data = {59'd0, item_q.random_value};
          5'd7, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd31:
            res_d.read_data = latch_q;
          default: res_d.read_data = regs_q[item_q.reg_index];
        endcase
      end
      CMD_WRITE_REG: res_d.random_reset = (item_q.reg_index == 5'd6);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q <= 1'b1;
      cnt_q <= '0;
      cmp_idx_q <= '0;
      out_valid_q <= 1'b0;
      latch_q <= '0;
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= clr_q ? ((cnt_q == Last) ? '0 : cnt_q + 1'b1) : cnt_d;
      if (clr_q && cnt_q == Last) clr_q <= 1'b0;
      if (state_q == ST_PROBE) cmp_idx_q <= cnt_q;
      if (state_q == ST_PROBE_CMP) cmp_idx_q <= cnt_q;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_DONE) out_valid_q <= 1'b1;
      if (!clr_q) begin
        case (state_q)
          ST_RD: begin
            if (item_q.command == CMD_TLB_PROBE) regs_q[0] <= PROBE_MISS;
            if (item_q.command == CMD_WRITE_REG) begin
              latch_q <= item_q.write_value;
              case (item_q.reg_index)
                5'd0: regs_q[0] <= item_q.write_value & MASK_INDEX;
                5'd2, 5'd3: regs_q[item_q.reg_index] <= item_q.write_value & MASK_LO;
                5'd4: regs_q[4] <= (item_q.write_value & ~64'h7f_ffff)
                                   | (regs_q[4] & 64'h7f_fff0);
                5'd5: regs_q[5] <= item_q.write_value & MASK_PAGEMASK;
                5'd6: regs_q[6] <= item_q.write_value & 64'h3f;
                5'd9, 5'd17, 5'd28:
                  regs_q[item_q.reg_index] <= item_q.write_value & 64'hffff_ffff;
                5'd10: regs_q[10] <= item_q.write_value & MASK_ENTRYHI;
                5'd11: begin
                  regs_q[11] <= item_q.write_value & 64'hffff_ffff;
                  regs_q[13] <= regs_q[13] & ~64'h8000;
                end
                5'd12: regs_q[12] <= (item_q.write_value & MASK_STATUS)
                                     | (regs_q[12] & 64'h20_0000);
                5'd13: regs_q[13] <= (regs_q[13] & ~64'h300)
                                     | (item_q.write_value & 64'h300);
                5'd14, 5'd30: regs_q[item_q.reg_index] <= item_q.write_value;
                5'd16: regs_q[16] <= (regs_q[16] & ~MASK_CONFIG)
                                     | (item_q.write_value & MASK_CONFIG);
                5'd18: regs_q[18] <= item_q.write_value & MASK_WATCHLO;
                5'd19: regs_q[19] <= item_q.write_value & 64'hf;
                5'd20: regs_q[20] <= (item_q.write_value & ~MASK_XCTX)
                                     | (regs_q[20] & 64'h1_ffff_fff0);
                5'd26: regs_q[26] <= item_q.write_value & 64'hff;
                5'd27: regs_q[27] <= '0;
                default: ;
              endcase
            end
          end
          ST_RD_WB: begin
            regs_q[5] <= {39'd0, rmask};
            regs_q[10] <= rhigh;
            regs_q[2] <= {38'd0, rlo0};
            regs_q[3] <= {38'd0, rlo1};
          end
          ST_PROBE_CMP: begin
            if (match) regs_q[0] <= {58'd0, 6'(cmp_idx_q)};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) item_q <= in_data_i;
    if (state_q == ST_RD) res_q <= res_d;
  end
endmodule

>>> src/cop0_tlb_mem.sv
`timescale 1ns / 1ps
module cop0_tlb_mem #(
  parameter int unsigned TlbEntries = 32,
  parameter int unsigned IdxW = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [24:0]     wmask_i,
  input  logic [63:0]     whigh_i,
  input  logic [25:0]     wlo0_i,
  input  logic [25:0]     wlo1_i,
  input  logic            wg_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [24:0]     rmask_o,
  output logic [63:0]     rhigh_o,
  output logic [25:0]     rlo0_o,
  output logic [25:0]     rlo1_o,
  output logic            rg_o
);
  logic [24:0] mask_mem [TlbEntries];
  logic [63:0] high_mem [TlbEntries];
  logic [25:0] lo0_mem  [TlbEntries];
  logic [25:0] lo1_mem  [TlbEntries];
  logic        g_mem    [TlbEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mask_mem[waddr_i] <= wmask_i;
      high_mem[waddr_i] <= whigh_i;
      lo0_mem[waddr_i]  <= wlo0_i;
      lo1_mem[waddr_i]  <= wlo1_i;
      g_mem[waddr_i]    <= wg_i;
    end
    rmask_o <= mask_mem[raddr_i];
    rhigh_o <= high_mem[raddr_i];
    rlo0_o  <= lo0_mem[raddr_i];
    rlo1_o  <= lo1_mem[raddr_i];
    rg_o    <= g_mem[raddr_i];
  end
endmodule
